### rtl/core/rpd_pkg.sv
// ============================================================================
// rpd_pkg - shared types, constants and functions
// Hook event codes, pin indexes, settle-event struct, digit and keypad helpers.
// ============================================================================
package rpd_pkg;

    localparam int unsigned PIN_COUNT   = 3;
    localparam int unsigned HOOK_IDX    = 0;
    localparam int unsigned DIAL_IDX    = 1;
    localparam int unsigned PULSE_IDX   = 2;

    localparam logic [7:0] COUNT_MAX     = 8'hFF;
    localparam logic [7:0] TICKS_DEFAULT = 8'd10;
    localparam logic [7:0] DIGIT_BASE    = 8'd10;

    // Reciprocal of 10 in Q11: exact quotient for any 8-bit value
    localparam logic [7:0] RECIP_TEN    = 8'd205;
    localparam int unsigned RECIP_SHIFT = 11;

    typedef enum logic [1:0] {
        HOOK_NONE = 2'd0,
        HOOK_HIGH = 2'd1,
        HOOK_LOW  = 2'd2
    } hook_event_t;

    // Stable-level changes found on one beat
    typedef struct packed {
        logic hook_chg;    // hook stable level changed
        logic hook_lvl;    // new hook stable level
        logic dial_chg;    // dial stable level changed
        logic dial_rest;   // dial stable level after update (1 = at rest)
        logic pulse_rise;  // pulse stable level went high
    } settle_t;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
    } key_pos_t;

    // count mod 10 via reciprocal multiply
    function automatic logic [3:0] digit_of(input logic [7:0] count);
        logic [15:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rem;
        prod = count * RECIP_TEN;
        quot = prod[15:RECIP_SHIFT] & 8'h1F;
        rem  = count - 8'(quot * DIGIT_BASE);
        return rem[3:0];
    endfunction

    // 4x3 keypad position of a digit: 1-3 row 0 ... 0 at row 3, column 1
    function automatic key_pos_t key_pos_of(input logic [3:0] digit);
        key_pos_t p;
        unique case (digit)
            4'd1:    p = '{row: 2'd0, col: 2'd0};
            4'd2:    p = '{row: 2'd0, col: 2'd1};
            4'd3:    p = '{row: 2'd0, col: 2'd2};
            4'd4:    p = '{row: 2'd1, col: 2'd0};
            4'd5:    p = '{row: 2'd1, col: 2'd1};
            4'd6:    p = '{row: 2'd1, col: 2'd2};
            4'd7:    p = '{row: 2'd2, col: 2'd0};
            4'd8:    p = '{row: 2'd2, col: 2'd1};
            4'd9:    p = '{row: 2'd2, col: 2'd2};
            default: p = '{row: 2'd3, col: 2'd1};
        endcase
        return p;
    endfunction

endpackage

### rtl/core/rpd_if.sv
// ============================================================================
// rpd_if - channel interfaces
// Poll input, result output and configuration write channels.
// ============================================================================
interface rpd_poll_if;
    logic valid;
    logic ready;
    logic hook_level;
    logic dial_level;
    logic pulse_level;
    logic timer_tick;

    modport source (output valid, hook_level, dial_level, pulse_level, timer_tick,
                    input ready);
    modport sink   (input valid, hook_level, dial_level, pulse_level, timer_tick,
                    output ready);
endinterface

interface rpd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] hook_event;
    logic       digit_valid;
    logic [3:0] digit;
    logic [1:0] key_row;
    logic [1:0] key_col;

    modport source (output valid, hook_event, digit_valid, digit, key_row, key_col,
                    input ready);
    modport sink   (input valid, hook_event, digit_valid, digit, key_row, key_col,
                    output ready);
endinterface

interface rpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/rotary_pulse_dial_decoder.sv
// ============================================================================
// rotary_pulse_dial_decoder - debounced rotary dial and hook decoder
// Input register, debounce and digit logic, result register.
// ============================================================================
// Each poll beat carries the raw hook, dial off-normal and pulse contact pin
// levels plus a timer-tick flag, and yields exactly one result beat: a hook
// event (stable high / stable low), and, when the dial returns to rest after
// counting pulses, the digit (pulse count mod 10) with its 4x3 keypad row and
// column. One poll is accepted per clock while the input register is empty or
// moving on; a poll is held in the input register and passes into the result
// register once that register is free or its result is taken, and the input
// register lets a new poll in while a finished result still waits.
// debounce_ticks is written through the cfg channel (always ready, reset 10)
// and must only be changed while no poll is in flight.
// ============================================================================
module rotary_pulse_dial_decoder
    import rpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rpd_poll_if.sink     poll,
    rpd_result_if.source result,
    rpd_cfg_if.sink      cfg
);

    // configuration
    logic [7:0] debounce_ticks_reg;

    // input stage
    logic                 s1_valid_reg;
    logic [PIN_COUNT-1:0] s1_raw_reg;
    logic                 s1_tick_reg;

    // result stage
    logic        out_valid_reg;
    hook_event_t out_hook_reg, out_hook_next;
    logic        out_dv_reg;
    logic [3:0]  out_digit_reg;
    logic [1:0]  out_row_reg;
    logic [1:0]  out_col_reg;

    logic        advance;
    settle_t     ev;
    logic        dv;
    logic [3:0]  dg;
    logic [1:0]  row;
    logic [1:0]  col;

    // the input stage moves on whenever the result slot is free or draining
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !s1_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_ticks_reg <= TICKS_DEFAULT;
        else if (cfg.valid)
            debounce_ticks_reg <= cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.ready)
                s1_valid_reg <= poll.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            s1_raw_reg  <= {poll.pulse_level, poll.dial_level, poll.hook_level};
            s1_tick_reg <= poll.timer_tick;
        end
    end

    rpd_debounce u_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .raw   (s1_raw_reg),
        .tick  (s1_tick_reg),
        .thr   (debounce_ticks_reg),
        .ev    (ev)
    );

    rpd_digit u_digit (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .tick        (s1_tick_reg),
        .ev          (ev),
        .digit_valid (dv),
        .digit       (dg),
        .key_row     (row),
        .key_col     (col)
    );

    always_comb
    begin
        if (!ev.hook_chg)
            out_hook_next = HOOK_NONE;
        else if (ev.hook_lvl)
            out_hook_next = HOOK_HIGH;
        else
            out_hook_next = HOOK_LOW;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hook_reg  <= out_hook_next;
            out_dv_reg    <= dv;
            out_digit_reg <= dg;
            out_row_reg   <= row;
            out_col_reg   <= col;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.hook_event  = out_hook_reg;
    assign result.digit_valid = out_dv_reg;
    assign result.digit       = out_digit_reg;
    assign result.key_row     = out_row_reg;
    assign result.key_col     = out_col_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_full_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        poll.valid && poll.ready && s1_valid_reg |-> advance)
        else $error("poll accepted over a held input stage");

    a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.digit_valid |->
            result.digit == 4'd0 && result.key_row == 2'd0 && result.key_col == 2'd0)
        else $error("digit fields nonzero without a digit");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.digit_valid |->
            result.digit <= 4'd9 && result.key_col <= 2'd2)
        else $error("digit or column out of range");

    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.digit_valid && result.digit == 4'd0 |->
            result.key_row == 2'd3 && result.key_col == 2'd1)
        else $error("digit zero mapped to wrong key");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

endmodule

### rtl/core/rpd_debounce.sv
// ============================================================================
// rpd_debounce - three-pin debouncer
// Per-pin tick counters, last raw and stable levels; reports stable changes.
// ============================================================================
module rpd_debounce
    import rpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [PIN_COUNT-1:0] raw,
    input  logic                 tick,
    input  logic [7:0]           thr,
    output settle_t              ev
);

    logic [PIN_COUNT-1:0] last_reg, last_next;
    logic [PIN_COUNT-1:0] stable_reg, stable_next;
    logic [7:0]           cnt_reg  [PIN_COUNT];
    logic [7:0]           cnt_next [PIN_COUNT];
    logic [PIN_COUNT-1:0] hit;
    logic                 pulse_hit;

    always_comb
    begin
        logic [7:0] c0;
        logic [7:0] c1;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            c0          = (raw[i] != last_reg[i]) ? 8'd0 : cnt_reg[i];
            c1          = (tick && c0 != COUNT_MAX) ? c0 + 8'd1 : c0;
            hit[i]      = tick && (c1 == thr) && (stable_reg[i] != raw[i]);
            cnt_next[i] = (tick && c1 > thr) ? thr : c1;
        end
        last_next = raw;

        stable_next           = stable_reg;
        stable_next[HOOK_IDX] = hit[HOOK_IDX] ? raw[HOOK_IDX] : stable_reg[HOOK_IDX];
        stable_next[DIAL_IDX] = hit[DIAL_IDX] ? raw[DIAL_IDX] : stable_reg[DIAL_IDX];
        // pulse contact is only tracked while the dial is off-normal
        pulse_hit              = hit[PULSE_IDX] && !stable_next[DIAL_IDX];
        stable_next[PULSE_IDX] = pulse_hit ? raw[PULSE_IDX] : stable_reg[PULSE_IDX];
    end

    always_comb
    begin
        ev.hook_chg   = hit[HOOK_IDX];
        ev.hook_lvl   = stable_next[HOOK_IDX];
        ev.dial_chg   = hit[DIAL_IDX];
        ev.dial_rest  = stable_next[DIAL_IDX];
        ev.pulse_rise = pulse_hit && raw[PULSE_IDX];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            stable_reg <= '0;
            for (int i = 0; i < PIN_COUNT; i++)
            begin
                cnt_reg[i] <= 8'd0;
            end
        end
        else if (en)
        begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            for (int i = 0; i < PIN_COUNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

### rtl/core/rpd_digit.sv
// ============================================================================
// rpd_digit - pulse counter and digit decode
// Counts pulses while off-normal; emits digit and keypad position at rest.
// ============================================================================
module rpd_digit
    import rpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       tick,
    input  settle_t    ev,
    output logic       digit_valid,
    output logic [3:0] digit,
    output logic [1:0] key_row,
    output logic [1:0] key_col
);

    logic [7:0] pulse_count_reg, pulse_count_next;
    logic [3:0] digit_raw;
    key_pos_t   pos;

    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        if (tick)
        begin
            if (ev.dial_rest)
                pulse_count_next = 8'd0;
            else if (ev.pulse_rise && pulse_count_reg != COUNT_MAX)
                pulse_count_next = pulse_count_reg + 8'd1;
        end
    end

    always_comb
    begin
        digit_raw   = digit_of(pulse_count_reg);
        pos         = key_pos_of(digit_raw);
        // dial just came back to rest with pulses pending
        digit_valid = tick && ev.dial_chg && ev.dial_rest && (pulse_count_reg != 8'd0);
        digit       = digit_valid ? digit_raw : 4'd0;
        key_row     = digit_valid ? pos.row : 2'd0;
        key_col     = digit_valid ? pos.col : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pulse_count_reg <= 8'd0;
        else if (en)
            pulse_count_reg <= pulse_count_next;
    end

endmodule
